[src/tts_pkg.sv]
// Shared types, register codes and reset values for the TDM turn scheduler.
// Used by the controller, the datapath and the top level.
package tts_pkg;

    localparam int MaxDomainsDefault = 16;

    // Configuration register indexes
    localparam logic [3:0] RegFirstLen   = 4'd0;
    localparam logic [3:0] RegOtherLen   = 4'd1;
    localparam logic [3:0] RegDomCount   = 4'd2;
    localparam logic [3:0] RegRefInt     = 4'd3;
    localparam logic [3:0] RegNormDead   = 4'd4;
    localparam logic [3:0] RegRefDead    = 4'd5;
    localparam logic [3:0] RegAllocMode  = 4'd6;
    localparam logic [3:0] RegMonoDead   = 4'd7;

    // Allocator modes
    localparam logic [1:0] ModeTdm      = 2'd0;
    localparam logic [1:0] ModePreempt  = 2'd1;
    localparam logic [1:0] ModePriority = 2'd2;

    // Register reset values
    localparam logic [15:0] RstFirstLen  = 16'd64;
    localparam logic [15:0] RstOtherLen  = 16'd64;
    localparam logic [4:0]  RstDomCount  = 5'd2;
    localparam logic [15:0] RstRefInt    = 16'd7800;
    localparam logic [9:0]  RstNormDead  = 10'd43;
    localparam logic [9:0]  RstRefDead   = 10'd120;

    // Controller states
    typedef enum logic [3:0] {
        ST_LEN  = 4'b0001,
        ST_INIT = 4'b0010,
        ST_WALK = 4'b0100,
        ST_RUN  = 4'b1000
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic calc_len;   // latch schedule length, clamp refresh phase
        logic init_seek;  // clamp position, start at turn zero
        logic walk;       // advance turn bounds toward the position
        logic step;       // one tick transfer accepted
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic seek_done;  // turn bounds enclose the position
    } t_stat;

    // Budget of domain i at the start of an epoch of n domains
    function automatic logic signed [7:0] fresh_budget(input logic [4:0] n, input int i);
        logic [4:0] iv;
        iv = 5'(i);
        return (iv < n) ? $signed(8'(n - 5'd1 - iv)) : 8'sd0;
    endfunction

endpackage

[src/tdm_turn_scheduler_with_dead_time.sv]
// TDM turn scheduler with dead time, top level: controller plus datapath.
// Result registered the cycle after the tick transfer; one tick per cycle unless stalled.
// After reset or any register write a recompute (states LEN, INIT, WALK)
// locates the position in the schedule; no tick is taken meanwhile.
// Reset (synchronous, active low) loads register defaults and zeroes the schedule position.
// Depends on tts_pkg, tts_ctrl and tts_dpath.
module tdm_turn_scheduler_with_dead_time #(
    parameter int MAX_DOMAINS = tts_pkg::MaxDomainsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] pending_mask
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [3:0] current owner, [7:4] upcoming_owner,
                                        // [11:8] scheduled_domain, [12] dead_time,
                                        // [13] turn_begins, [15:14] zero
);
    import tts_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;

    tts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    tts_dpath #(.MAX_DOMAINS(MAX_DOMAINS)) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_mask      (s_axis_tdata),
        .o_result    (m_axis_tdata)
    );

endmodule

[src/tts_ctrl.sv]
// Controller of the TDM turn scheduler: recompute sequence after reset or a
// register write, then one tick per cycle unless the output holding register is stalled.
// Depends on tts_pkg.
module tts_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output tts_pkg::t_cmd  o_cmd,
    input  tts_pkg::t_stat i_stat
);
    import tts_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;

    // Accept when running and the output slot is empty or frees this cycle
    assign o_in_ready  = (r_state == ST_RUN) && (!r_out_valid || i_out_ready);
    assign accept      = o_in_ready && i_in_valid;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.calc_len  = (r_state == ST_LEN);
        o_cmd.init_seek = (r_state == ST_INIT);
        o_cmd.walk      = (r_state == ST_WALK);
        o_cmd.step      = accept;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LEN:  n_state = ST_INIT;
            ST_INIT: n_state = ST_WALK;
            ST_WALK: if (i_stat.seek_done) n_state = ST_RUN;
            ST_RUN:  n_state = ST_RUN;
            default: n_state = ST_LEN;
        endcase
        if (i_cfg_we) n_state = ST_LEN;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_out_ready) n_out_valid = 1'b0;
        if (accept)      n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LEN;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_ready_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == ST_RUN)
        else $error("input taken outside run state");
    a_cfg_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> r_state == ST_LEN)
        else $error("register write did not restart recompute");
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted tick produced no result");

endmodule

[src/tts_dpath.sv]
// Datapath of the TDM turn scheduler: registers, schedule tracking, allocators,
// dead-time test and the result register. Depends on tts_pkg.
module tts_dpath #(
    parameter int MAX_DOMAINS = tts_pkg::MaxDomainsDefault
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [3:0]     i_cfg_index,
    input  logic [15:0]    i_cfg_data,
    input  tts_pkg::t_cmd  i_cmd,
    output tts_pkg::t_stat o_stat,
    input  logic [15:0]    i_mask,
    output logic [15:0]    o_result
);
    import tts_pkg::*;

    localparam logic [4:0] MaxN = 5'(MAX_DOMAINS);

    // Configuration registers
    logic [15:0] r_p0, r_p1, r_ref_int;
    logic [4:0]  r_dom_cnt;
    logic [9:0]  r_norm_dead, r_ref_dead;
    logic [1:0]  r_mode;
    logic        r_mono;

    // Schedule tracking
    logic [19:0] r_len, r_s, r_ts, r_te;
    logic [3:0]  r_nat;
    logic [15:0] r_rp;
    logic [3:0]  r_owner, r_next;
    logic [4:0]  r_epoch;
    logic signed [7:0] r_budget [MAX_DOMAINS];
    logic [15:0] r_result;

    logic [15:0] p0e, p1e, ref_e;
    logic [4:0]  n_eff;
    logic [3:0]  top, nat_next;
    logic [1:0]  mode_e;
    logic        begins, alloc, last_turn;
    logic [20:0] s_plus1, refresh_at, dead_end;
    logic        refresh_in;
    logic [9:0]  dead;
    logic [3:0]  pre_win, pri_win, nxt_alloc, cur, nxt, n_owner, n_next;
    logic [4:0]  epoch_base, epoch_new;
    logic signed [7:0] base [MAX_DOMAINS];
    logic signed [7:0] n_budget [MAX_DOMAINS];

    // Effective settings
    assign p0e    = (r_p0 == 16'd0) ? 16'd1 : r_p0;
    assign p1e    = (r_p1 == 16'd0) ? 16'd1 : r_p1;
    assign ref_e  = (r_ref_int == 16'd0) ? 16'd1 : r_ref_int;
    assign n_eff  = (r_dom_cnt < 5'd2) ? 5'd2 : ((r_dom_cnt > MaxN) ? MaxN : r_dom_cnt);
    assign top    = 4'(n_eff - 5'd1);
    assign mode_e = (r_mode == ModePreempt || r_mode == ModePriority) ? r_mode : ModeTdm;

    // Turn boundaries
    assign nat_next  = (r_nat >= top) ? 4'd0 : r_nat + 4'd1;
    assign s_plus1   = {1'b0, r_s} + 21'd1;
    assign begins    = (r_s == r_ts);
    assign alloc     = (s_plus1 == {1'b0, r_te});
    assign last_turn = (r_nat >= top);
    assign o_stat.seek_done = (r_s < r_te);

    // Preempting: first pending domain from the natural next one up, else top
    always_comb begin
        pre_win = top;
        for (int d = MAX_DOMAINS - 1; d >= 0; d--) begin
            if (4'(d) >= nat_next && 4'(d) < top && i_mask[d]) pre_win = 4'(d);
        end
    end

    // Priority with epoch budget
    always_comb begin
        epoch_base = (r_epoch == 5'd0) ? n_eff : r_epoch;
        epoch_new  = epoch_base - 5'd1;
        for (int d = 0; d < MAX_DOMAINS; d++) begin
            base[d] = (r_epoch == 5'd0) ? fresh_budget(n_eff, d) : r_budget[d];
        end
        pri_win = top;
        for (int d = MAX_DOMAINS - 1; d >= 0; d--) begin
            if (4'(d) < top && $signed({3'b000, epoch_new}) > base[d] && i_mask[d])
                pri_win = 4'(d);
        end
        for (int d = 0; d < MAX_DOMAINS; d++) begin
            n_budget[d] = (4'(d) < pri_win) ? base[d] - 8'sd1 : base[d];
        end
    end

    // Owner handover
    always_comb begin
        nxt_alloc = r_next;
        if (alloc) begin
            priority case (mode_e)
                ModePreempt:  nxt_alloc = pre_win;
                ModePriority: nxt_alloc = pri_win;
                default:      nxt_alloc = r_next;
            endcase
        end
        n_owner = r_owner;
        n_next  = nxt_alloc;
        if (begins && mode_e != ModeTdm) begin
            n_owner = nxt_alloc;
            n_next  = (mode_e == ModePreempt) ? nat_next : 4'd0;
        end
        cur = (mode_e == ModeTdm) ? r_nat : n_owner;
        nxt = (mode_e == ModeTdm) ? nat_next : n_next;
    end

    // Dead time
    always_comb begin
        refresh_at = {1'b0, r_s} + 21'(ref_e - r_rp);
        refresh_in = refresh_at < {1'b0, r_te};
        dead       = refresh_in ? r_ref_dead : r_norm_dead;
        if (r_mono && cur <= nxt) dead = 10'd0;
        dead_end   = {1'b0, r_s} + 21'(dead);
    end

    assign o_result = r_result;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0        <= RstFirstLen;
            r_p1        <= RstOtherLen;
            r_dom_cnt   <= RstDomCount;
            r_ref_int   <= RstRefInt;
            r_norm_dead <= RstNormDead;
            r_ref_dead  <= RstRefDead;
            r_mode      <= ModeTdm;
            r_mono      <= 1'b0;
        end else if (i_cfg_we) begin
            priority case (i_cfg_index)
                RegFirstLen:  r_p0        <= i_cfg_data;
                RegOtherLen:  r_p1        <= i_cfg_data;
                RegDomCount:  r_dom_cnt   <= i_cfg_data[4:0];
                RegRefInt:    r_ref_int   <= i_cfg_data;
                RegNormDead:  r_norm_dead <= i_cfg_data[9:0];
                RegRefDead:   r_ref_dead  <= i_cfg_data[9:0];
                RegAllocMode: r_mode      <= i_cfg_data[1:0];
                RegMonoDead:  r_mono      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Schedule length and turn bounds (payload, rebuilt by recompute)
    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_len) r_len <= 20'(p0e) + 20'(p1e) * 20'(top);
        if (i_cmd.init_seek) begin
            r_nat <= 4'd0;
            r_ts  <= 20'd0;
            r_te  <= 20'(p0e);
        end else if (i_cmd.walk && r_s >= r_te) begin
            r_nat <= r_nat + 4'd1;
            r_ts  <= r_te;
            r_te  <= r_te + 20'(p1e);
        end else if (i_cmd.step && alloc) begin
            if (last_turn) begin
                r_nat <= 4'd0;
                r_ts  <= 20'd0;
                r_te  <= 20'(p0e);
            end else begin
                r_nat <= r_nat + 4'd1;
                r_ts  <= r_te;
                r_te  <= r_te + 20'(p1e);
            end
        end
        if (i_cmd.step)
            r_result <= {2'b00, begins, dead_end >= {1'b0, r_te}, r_nat, nxt, cur};
    end

    // Position, refresh phase and allocator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s     <= 20'd0;
            r_rp    <= 16'd0;
            r_owner <= 4'd0;
            r_next  <= 4'd0;
            r_epoch <= RstDomCount;
            for (int d = 0; d < MAX_DOMAINS; d++) r_budget[d] <= fresh_budget(RstDomCount, d);
        end else begin
            if (i_cmd.calc_len && r_rp >= ref_e) r_rp <= ref_e - 16'd1;
            if (i_cmd.init_seek && r_s >= r_len) r_s <= 20'd0;
            if (i_cmd.step) begin
                r_s  <= (alloc && last_turn) ? 20'd0 : s_plus1[19:0];
                r_rp <= (r_rp + 16'd1 >= ref_e) ? 16'd0 : r_rp + 16'd1;
                if (mode_e != ModeTdm) begin
                    r_owner <= n_owner;
                    r_next  <= n_next;
                end
                if (alloc && mode_e == ModePriority) begin
                    r_epoch <= epoch_new;
                    for (int d = 0; d < MAX_DOMAINS; d++) r_budget[d] <= n_budget[d];
                end
            end
        end
    end

    a_pos_in_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_s >= r_ts && r_s < r_te))
        else $error("position outside tracked turn");
    a_nat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> r_nat <= top)
        else $error("natural domain beyond last domain");
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> r_rp < ref_e)
        else $error("refresh phase past interval");

endmodule
